>>> hw/rtl/ims_pkg.sv
// shared types and constants of the interval matcher
`default_nettype none
package ims_pkg;

	localparam int OPEN_SLOTS_DEF = 16;
	localparam int NUM_STAGES     = 5;
	localparam int TIME_W         = 64;
	localparam int FRAME_W        = 32;
	localparam int STAGE_W        = 3;
	localparam int COUNT_W        = 32;
	localparam int OPEN_W         = 5;

	localparam logic [STAGE_W-1:0] STAGE_SINK = 3'd4;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_DUP     = 3'd1;
	localparam logic [2:0] STS_NOMATCH = 3'd2;
	localparam logic [2:0] STS_EARLY   = 3'd3;
	localparam logic [2:0] STS_FULL    = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DIFF,
		S_FOLD
	} state_t;

	// token that walks the slot chain, one cell per cycle
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic              free;
		logic [TIME_W-1:0] start;
	} scan_t;

	// broadcast commit to the marked cells
	typedef struct packed {
		logic set;
		logic clr;
	} commit_t;

endpackage
`default_nettype wire

>>> hw/rtl/ims_cell.sv
// one slot of the open interval table, with its stage of the scan chain
`default_nettype none
module ims_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ims_pkg::FRAME_W-1:0]  key_frame,
	input  wire logic [ims_pkg::STAGE_W-1:0]  key_stage,
	input  wire logic [ims_pkg::TIME_W-1:0]   key_time,
	input  wire ims_pkg::scan_t               scan_in,
	output ims_pkg::scan_t                    scan_out,
	input  wire ims_pkg::commit_t             commit,
	output logic                              valid
);
	import ims_pkg::*;

	logic               valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic [STAGE_W-1:0] stage_q;
	logic [TIME_W-1:0]  start_q;
	logic               vld_q;
	logic               hit_q;
	logic               free_q;
	logic [TIME_W-1:0]  tstart_q;
	logic               hit_mark_q;
	logic               free_mark_q;
	logic               hit;

	assign hit = valid_q && (frame_q == key_frame) && (stage_q == key_stage);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= 1'b0;
			valid_q     <= 1'b0;
			hit_mark_q  <= 1'b0;
			free_mark_q <= 1'b0;
		end else begin
			vld_q <= scan_in.vld;
			if (scan_in.vld) begin
				hit_mark_q  <= hit;
				free_mark_q <= !valid_q && !scan_in.free;
			end
			if (commit.set && free_mark_q) begin
				valid_q <= 1'b1;
			end else if (commit.clr && hit_mark_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.vld) begin
			hit_q    <= scan_in.hit || hit;
			free_q   <= scan_in.free || !valid_q;
			tstart_q <= hit ? start_q : scan_in.start;
		end
		if (commit.set && free_mark_q) begin
			frame_q <= key_frame;
			stage_q <= key_stage;
			start_q <= key_time;
		end
	end

	assign scan_out = '{vld: vld_q, hit: hit_q, free: free_q, start: tstart_q};
	assign valid    = valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/ims_stats.sv
// per-stage count, total, min and max with their update logic
`default_nettype none
module ims_stats (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ims_pkg::STAGE_W-1:0]  stage,
	input  wire logic [ims_pkg::TIME_W-1:0]   dur,
	input  wire logic                         upd,
	output logic [ims_pkg::COUNT_W-1:0]       cnt_cur,
	output logic [ims_pkg::TIME_W-1:0]        total_cur,
	output logic [ims_pkg::TIME_W-1:0]        min_cur,
	output logic [ims_pkg::TIME_W-1:0]        max_cur,
	output logic [ims_pkg::COUNT_W-1:0]       cnt_new,
	output logic [ims_pkg::TIME_W-1:0]        total_new,
	output logic [ims_pkg::TIME_W-1:0]        min_new,
	output logic [ims_pkg::TIME_W-1:0]        max_new
);
	import ims_pkg::*;

	logic [COUNT_W-1:0] cnt_q   [NUM_STAGES];
	logic [TIME_W-1:0]  total_q [NUM_STAGES];
	logic [TIME_W-1:0]  min_q   [NUM_STAGES];
	logic [TIME_W-1:0]  max_q   [NUM_STAGES];
	logic [TIME_W:0]    sum;

	assign cnt_cur   = cnt_q[stage];
	assign total_cur = total_q[stage];
	assign min_cur   = min_q[stage];
	assign max_cur   = max_q[stage];

	always_comb begin
		sum       = {1'b0, total_cur} + {1'b0, dur};
		cnt_new   = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
		total_new = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		// first duration of a stage seeds the minimum
		if (cnt_cur == '0) begin
			min_new = dur;
		end else begin
			min_new = (dur < min_cur) ? dur : min_cur;
		end
		max_new = (dur > max_cur) ? dur : max_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				cnt_q[i]   <= '0;
				total_q[i] <= '0;
				min_q[i]   <= '0;
				max_q[i]   <= '0;
			end
		end else if (upd) begin
			cnt_q[stage]   <= cnt_new;
			total_q[stage] <= total_new;
			min_q[stage]   <= min_new;
			max_q[stage]   <= max_new;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/interval_matcher_with_stage_stats.sv
// top level of the interval matcher with per-stage statistics
`default_nettype none
// begin/end/read events are taken with start while busy is low. every event
// gives exactly one result, shown for one cycle with done high; the result
// cannot be held off. busy stays high from the transfer until done rises, so
// one event is worked at a time and the next transfer can come at the edge
// that ends the done cycle. the steps: a search token walks the OPEN_SLOTS
// cells one per cycle, collecting the key match and the lowest free slot,
// the S_SCAN state captures what it found, S_DIFF forms the duration and
// S_FOLD folds it into the stage statistics and commits the slot change.
// stage_sel above 4 counts as the sink stage. fields an event does not use
// read zero.
module interval_matcher_with_stage_stats #(
	parameter int OPEN_SLOTS = ims_pkg::OPEN_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   op,
	input  wire logic [ims_pkg::FRAME_W-1:0]  frame_id,
	input  wire logic [ims_pkg::STAGE_W-1:0]  stage_sel,
	input  wire logic [ims_pkg::TIME_W-1:0]   time_ns,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [ims_pkg::FRAME_W-1:0]       rec_frame_id,
	output logic [ims_pkg::STAGE_W-1:0]       rec_stage,
	output logic [ims_pkg::TIME_W-1:0]        start_time,
	output logic [ims_pkg::TIME_W-1:0]        end_time,
	output logic [ims_pkg::TIME_W-1:0]        duration,
	output logic [ims_pkg::COUNT_W-1:0]       stage_count,
	output logic [ims_pkg::TIME_W-1:0]        stage_total,
	output logic [ims_pkg::TIME_W-1:0]        stage_min,
	output logic [ims_pkg::TIME_W-1:0]        stage_max,
	output logic [ims_pkg::OPEN_W-1:0]        open_count
);
	import ims_pkg::*;

	localparam int CW = $clog2(OPEN_SLOTS + 1);
	localparam int XW = (CW > OPEN_W) ? CW : OPEN_W;

	state_t state_q, state_d;

	// event held for the whole search
	logic [1:0]         op_q;
	logic [FRAME_W-1:0] frame_q;
	logic [STAGE_W-1:0] stage_q;
	logic [TIME_W-1:0]  time_q;
	logic               inj_q;

	// search outcome, then duration
	logic               hit_q;
	logic               free_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  dur_q;
	logic               late_q;

	logic [CW-1:0]      open_cnt_q;
	logic [CW-1:0]      open_cnt_d;

	// result registers
	logic               done_q;
	logic [2:0]         status_q;
	logic [FRAME_W-1:0] rec_frame_q;
	logic [STAGE_W-1:0] rec_stage_q;
	logic [TIME_W-1:0]  start_time_q;
	logic [TIME_W-1:0]  end_time_q;
	logic [TIME_W-1:0]  duration_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  total_q;
	logic [TIME_W-1:0]  min_q;
	logic [TIME_W-1:0]  max_q;
	logic [OPEN_W-1:0]  open_out_q;

	// next result values
	logic [2:0]         status_d;
	logic [FRAME_W-1:0] rec_frame_d;
	logic [STAGE_W-1:0] rec_stage_d;
	logic [TIME_W-1:0]  start_time_d;
	logic [TIME_W-1:0]  end_time_d;
	logic [TIME_W-1:0]  duration_d;
	logic [COUNT_W-1:0] count_d;
	logic [TIME_W-1:0]  total_d;
	logic [TIME_W-1:0]  min_d;
	logic [TIME_W-1:0]  max_d;
	logic [OPEN_W-1:0]  open_out_d;
	logic [XW-1:0]      open_ext;

	logic               accept;
	logic               end_ok;
	logic               begin_ok;
	commit_t            commit;
	logic [TIME_W:0]    diff;

	scan_t              chain [OPEN_SLOTS+1];
	logic [OPEN_SLOTS-1:0] valid_vec;

	logic [COUNT_W-1:0] cnt_cur, cnt_new;
	logic [TIME_W-1:0]  total_cur, total_new;
	logic [TIME_W-1:0]  min_cur, min_new;
	logic [TIME_W-1:0]  max_cur, max_new;

	assign accept = start && !busy;

	// ---------------------------------------------------------------- slot chain
	// the token enters cell 0 the cycle after the transfer, once the key is held
	assign chain[0] = '{vld: inj_q, hit: 1'b0, free: 1'b0, start: '0};

	for (genvar g = 0; g < OPEN_SLOTS; g++) begin : g_cell
		ims_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key_frame (frame_q),
			.key_stage (stage_q),
			.key_time  (time_q),
			.scan_in   (chain[g]),
			.scan_out  (chain[g+1]),
			.commit    (commit),
			.valid     (valid_vec[g])
		);
	end

	// ---------------------------------------------------------------- statistics
	ims_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage_q),
		.dur       (dur_q),
		.upd       (commit.clr),
		.cnt_cur   (cnt_cur),
		.total_cur (total_cur),
		.min_cur   (min_cur),
		.max_cur   (max_cur),
		.cnt_new   (cnt_new),
		.total_new (total_new),
		.min_new   (min_new),
		.max_new   (max_new)
	);

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (chain[OPEN_SLOTS].vld) state_d = S_DIFF;
			end
			S_DIFF: begin
				state_d = S_FOLD;
			end
			S_FOLD: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// begin fills the lowest free slot; an end that is in order frees its slot
	assign begin_ok = (op_q == OP_BEGIN) && !hit_q && free_q;
	assign end_ok   = (op_q == OP_END) && hit_q && !late_q;

	always_comb begin
		busy       = (state_q != S_IDLE);
		commit.set = (state_q == S_FOLD) && begin_ok;
		commit.clr = (state_q == S_FOLD) && end_ok;
	end

	// ---------------------------------------------------------------- result
	always_comb begin
		status_d     = STS_OK;
		rec_frame_d  = '0;
		rec_stage_d  = '0;
		start_time_d = '0;
		end_time_d   = '0;
		duration_d   = '0;
		count_d      = '0;
		total_d      = '0;
		min_d        = '0;
		max_d        = '0;
		open_cnt_d   = open_cnt_q;
		case (op_q)
			OP_BEGIN: begin
				if (hit_q) begin
					status_d = STS_DUP;
				end else if (!free_q) begin
					status_d = STS_FULL;
				end else begin
					open_cnt_d = open_cnt_q + CW'(1);
				end
			end
			OP_END: begin
				if (!hit_q) begin
					status_d = STS_NOMATCH;
				end else if (late_q) begin
					status_d = STS_EARLY;
				end else begin
					rec_frame_d  = frame_q;
					rec_stage_d  = stage_q;
					start_time_d = start_q;
					end_time_d   = time_q;
					duration_d   = dur_q;
					count_d      = cnt_new;
					total_d      = total_new;
					min_d        = min_new;
					max_d        = max_new;
					open_cnt_d   = open_cnt_q - CW'(1);
				end
			end
			OP_READ: begin
				rec_stage_d = stage_q;
				count_d     = cnt_cur;
				total_d     = total_cur;
				min_d       = min_cur;
				max_d       = max_cur;
			end
			default: begin
				status_d = STS_OK;
			end
		endcase
		// open count is reported clamped to 31
		open_ext   = XW'(open_cnt_d);
		open_out_d = (open_ext > XW'(31)) ? OPEN_W'(31) : open_ext[OPEN_W-1:0];
	end

	assign diff = {1'b0, time_q} - {1'b0, start_q};

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			inj_q      <= 1'b0;
			done_q     <= 1'b0;
			open_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			inj_q   <= accept;
			done_q  <= (state_q == S_FOLD);
			if (state_q == S_FOLD) begin
				open_cnt_q <= open_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			frame_q <= frame_id;
			stage_q <= (stage_sel > STAGE_SINK) ? STAGE_SINK : stage_sel;
			time_q  <= time_ns;
		end
		if (state_q == S_SCAN && chain[OPEN_SLOTS].vld) begin
			hit_q   <= chain[OPEN_SLOTS].hit;
			free_q  <= chain[OPEN_SLOTS].free;
			start_q <= chain[OPEN_SLOTS].start;
		end
		if (state_q == S_DIFF) begin
			dur_q  <= diff[TIME_W-1:0];
			late_q <= diff[TIME_W];
		end
		if (state_q == S_FOLD) begin
			status_q     <= status_d;
			rec_frame_q  <= rec_frame_d;
			rec_stage_q  <= rec_stage_d;
			start_time_q <= start_time_d;
			end_time_q   <= end_time_d;
			duration_q   <= duration_d;
			count_q      <= count_d;
			total_q      <= total_d;
			min_q        <= min_d;
			max_q        <= max_d;
			open_out_q   <= open_out_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign rec_frame_id = rec_frame_q;
	assign rec_stage    = rec_stage_q;
	assign start_time   = start_time_q;
	assign end_time     = end_time_q;
	assign duration     = duration_q;
	assign stage_count  = count_q;
	assign stage_total  = total_q;
	assign stage_min    = min_q;
	assign stage_max    = max_q;
	assign open_count   = open_out_q;

	// ---------------------------------------------------------------- checks
	// the open counter tracks the valid slots in the chain
	a_open_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(open_cnt_q))
		else $error("open count differs from valid slots");

	// a result only follows the fold step
	a_done_fold: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FOLD))
		else $error("result without fold");

	// the token leaves the chain only while the block waits for it
	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[OPEN_SLOTS].vld |-> state_q == S_SCAN)
		else $error("scan token outside scan");

	// set and clear are never issued together
	a_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit.set && commit.clr))
		else $error("slot set and clear together");

endmodule
`default_nettype wire
